// ===== rtl/core/ppfc_pkg.sv =====
// Package for the PNG pixel format converter.
// Format codes, the four-channel transaction type and the divide-by-0x101 helper.
// No dependencies.
package ppfc_pkg;

   typedef enum logic [3:0] {
      FMT_GS1    = 4'd0,
      FMT_GS2    = 4'd1,
      FMT_GS4    = 4'd2,
      FMT_GS8    = 4'd3,
      FMT_GS16   = 4'd4,
      FMT_GSA8   = 4'd5,
      FMT_GSA16  = 4'd6,
      FMT_RGB8   = 4'd7,
      FMT_RGB16  = 4'd8,
      FMT_RGBA8  = 4'd9,
      FMT_RGBA16 = 4'd10
   } fmt_type;

   typedef enum logic {
      CSR_SOURCE_FORMAT = 1'b0,
      CSR_TARGET_FORMAT = 1'b1
   } csr_idx_type;

   localparam int unsigned FMT_W = 4;

   typedef struct packed {
      logic [15:0] r;
      logic [15:0] g;
      logic [15:0] b;
      logic [15:0] a;
   } chan_type;

   // floor(v / 257): v = 256h + l, quotient is h when l >= h, else h - 1
   function automatic logic [7:0] div257(input logic [15:0] v);
      logic [7:0] h;
      h = v[15:8];
      return (v[7:0] >= h) ? h : h - 8'd1;
   endfunction

endpackage

// ===== rtl/core/ppfc_expand.sv =====
// Expands a packed source pixel to four 16-bit channels.
// Depends on ppfc_pkg.
module ppfc_expand
   import ppfc_pkg::*;
(
   input  logic [63:0]      pixel,
   input  logic [FMT_W-1:0] fmt,
   output chan_type         ch
);

   always_comb begin
      ch = '{r: 16'd0, g: 16'd0, b: 16'd0, a: 16'hFFFF};
      unique case (fmt)
         FMT_GS1: begin
            ch.r = {16{pixel[0]}};
            ch.g = ch.r;
            ch.b = ch.r;
         end
         FMT_GS2: begin
            ch.r = {8{pixel[1:0]}};
            ch.g = ch.r;
            ch.b = ch.r;
         end
         FMT_GS4: begin
            ch.r = {4{pixel[3:0]}};
            ch.g = ch.r;
            ch.b = ch.r;
         end
         FMT_GS8: begin
            ch.r = {2{pixel[7:0]}};
            ch.g = ch.r;
            ch.b = ch.r;
         end
         FMT_GS16: begin
            ch.r = pixel[15:0];
            ch.g = ch.r;
            ch.b = ch.r;
         end
         FMT_GSA8: begin
            ch.r = {2{pixel[15:8]}};
            ch.g = ch.r;
            ch.b = ch.r;
            ch.a = {2{pixel[7:0]}};
         end
         FMT_GSA16: begin
            ch.r = pixel[31:16];
            ch.g = ch.r;
            ch.b = ch.r;
            ch.a = pixel[15:0];
         end
         FMT_RGB8: begin
            ch.r = {2{pixel[23:16]}};
            ch.g = {2{pixel[15:8]}};
            ch.b = {2{pixel[7:0]}};
         end
         FMT_RGB16: begin
            ch.r = pixel[47:32];
            ch.g = pixel[31:16];
            ch.b = pixel[15:0];
         end
         FMT_RGBA8: begin
            ch.r = {2{pixel[31:24]}};
            ch.g = {2{pixel[23:16]}};
            ch.b = {2{pixel[15:8]}};
            ch.a = {2{pixel[7:0]}};
         end
         default: begin
            ch.r = pixel[63:48];
            ch.g = pixel[47:32];
            ch.b = pixel[31:16];
            ch.a = pixel[15:0];
         end
      endcase
   end

endmodule

// ===== rtl/core/ppfc_pack.sv =====
// Packs four 16-bit channels into the target format and flags unsupported pairs.
// Depends on ppfc_pkg.
module ppfc_pack
   import ppfc_pkg::*;
(
   input  chan_type         ch,
   input  logic [FMT_W-1:0] src,
   input  logic [FMT_W-1:0] tgt,
   output logic [63:0]      pixel,
   output logic             unsupported
);

   logic [17:0] sum;
   logic [37:0] prod;
   logic [15:0] q3;
   logic [7:0]  grey8;
   logic [3:0]  d4;
   logic [3:0]  grey4;
   logic [1:0]  d2;
   logic [1:0]  grey2;
   logic        grey1;
   logic [7:0]  r8;
   logic [7:0]  g8;
   logic [7:0]  b8;
   logic [7:0]  a8;
   logic [63:0] grey_rgb;
   logic        src_rgba;
   logic        alpha_check;

   // sum / 3 by reciprocal, exact for sum < 2^19
   assign sum  = {2'b00, ch.r} + {2'b00, ch.g} + {2'b00, ch.b};
   assign prod = sum * 20'h2AAAB;
   assign q3   = prod[34:19];

   assign grey8 = div257(q3);
   assign d4    = q3[15:12];
   assign grey4 = (q3 >= {4{d4}}) ? d4 : d4 - 4'd1;
   assign d2    = q3[15:14];
   assign grey2 = (q3 >= {8{d2}}) ? d2 : d2 - 2'd1;
   assign grey1 = &q3;

   assign r8 = div257(ch.r);
   assign g8 = div257(ch.g);
   assign b8 = div257(ch.b);
   assign a8 = div257(ch.a);

   always_comb begin
      case (tgt)
         FMT_GS1:   grey_rgb = {63'd0, grey1};
         FMT_GS2:   grey_rgb = {62'd0, grey2};
         FMT_GS4:   grey_rgb = {60'd0, grey4};
         FMT_GS8:   grey_rgb = {56'd0, grey8};
         FMT_GS16:  grey_rgb = {48'd0, q3};
         FMT_GSA8:  grey_rgb = {48'd0, grey8, a8};
         FMT_GSA16: grey_rgb = {32'd0, q3, ch.a};
         FMT_RGB8:  grey_rgb = {40'd0, r8, g8, b8};
         default:   grey_rgb = {16'd0, ch.r, ch.g, ch.b};
      endcase
   end

   assign src_rgba    = (src == FMT_RGBA8) || (src == FMT_RGBA16);
   assign alpha_check = !((src == FMT_RGBA8) && ((tgt == FMT_RGB8) || (tgt == FMT_RGB16)));

   always_comb begin
      pixel       = 64'd0;
      unsupported = 1'b0;
      if ((src > FMT_RGBA16) || (tgt > FMT_RGBA16)) begin
         unsupported = 1'b1;
      end else if (tgt == FMT_RGBA16) begin
         if (src == FMT_RGBA16) begin
            unsupported = 1'b1;
         end else begin
            pixel = {ch.r, ch.g, ch.b, ch.a};
         end
      end else if (tgt == FMT_RGBA8) begin
         if (src == FMT_RGBA8) begin
            unsupported = 1'b1;
         end else begin
            pixel = {32'd0, r8, g8, b8, a8};
         end
      end else if (src_rgba) begin
         if (!(alpha_check && (ch.a == 16'd0))) begin
            pixel = grey_rgb;
         end
      end else begin
         unsupported = 1'b1;
      end
   end

endmodule

// ===== rtl/core/png_pixel_format_converter.sv =====
// PNG pixel format converter, top level: format registers, input and result registers.
// An accepted transaction is held in the input registers, then its result in the result
// registers, which drive the strobe. Throughput: one pixel per cycle; busy stays low.
// Critical path: channel sum, one 18x20 constant multiply and the grey compare.
// Reset (synchronous): source RGBA16, target RGBA8, no transaction in flight.
// Depends on ppfc_pkg, ppfc_expand and ppfc_pack.
module png_pixel_format_converter
   import ppfc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [63:0]      req_pixel_in,
   output logic             rsp_strobe,
   output logic [63:0]      rsp_pixel_out,
   output logic             rsp_unsupported,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [FMT_W-1:0] csr_wdata
);

   logic [FMT_W-1:0] src_ff;
   logic [FMT_W-1:0] tgt_ff;
   logic             vld_ff;
   logic [63:0]      pix_ff;
   logic             rsp_strobe_ff;
   logic [63:0]      rsp_pixel_ff;
   logic             rsp_unsup_ff;
   logic [63:0]      rsp_pixel_in;
   logic             rsp_unsup_in;
   chan_type         ch;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_ff <= FMT_RGBA16;
         tgt_ff <= FMT_RGBA8;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_SOURCE_FORMAT: src_ff <= csr_wdata;
            CSR_TARGET_FORMAT: tgt_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         vld_ff        <= start && !busy;
         rsp_strobe_ff <= vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         pix_ff <= req_pixel_in;
      end
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_unsup_ff <= rsp_unsup_in;
   end

   ppfc_expand u_expand (
      .pixel (pix_ff),
      .fmt   (src_ff),
      .ch    (ch)
   );

   ppfc_pack u_pack (
      .ch          (ch),
      .src         (src_ff),
      .tgt         (tgt_ff),
      .pixel       (rsp_pixel_in),
      .unsupported (rsp_unsup_in)
   );

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_pixel_out   = rsp_pixel_ff;
   assign rsp_unsupported = rsp_unsup_ff;

`ifndef SYNTHESIS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_strobe)
      else $error("accepted transaction not strobed after two cycles");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(vld_ff))
      else $error("result strobed without a transaction");

   a_unsup_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_unsupported) |-> (rsp_pixel_out == 64'd0))
      else $error("unsupported result carries a non-zero pixel");

   a_bad_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (($past(src_ff) > FMT_RGBA16) || ($past(tgt_ff) > FMT_RGBA16)))
      |-> rsp_unsupported)
      else $error("illegal format code not flagged");
`endif

endmodule

// ===== sim/png_pixel_format_converter_test.sv =====
// Self-checking testbench for png_pixel_format_converter: directed and random pixels over
// many format pairs, checked against a scoreboard class that predicts each conversion.
// Depends on ppfc_pkg and the png_pixel_format_converter RTL.
`timescale 1ns / 1ps

module png_pixel_format_converter_test;
   import ppfc_pkg::*;

   localparam int RANDOM_PIXELS  = 830;
   localparam int QUIET_TAIL     = 150;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam logic [63:0] STEP_1BIT = 64'hFFFF;
   localparam logic [63:0] STEP_2BIT = 64'h5555;
   localparam logic [63:0] STEP_4BIT = 64'h1111;
   localparam logic [63:0] STEP_8BIT = 64'h0101;

   class pixel_scoreboard;
      logic [3:0]  src_fmt;
      logic [3:0]  dst_fmt;
      logic [63:0] exp_pixel[$];
      bit          exp_unsup[$];
      int          mismatches;

      function new();
         mismatches = 0;
         reset_formats();
      endfunction

      function void reset_formats();
         src_fmt = FMT_RGBA16;
         dst_fmt = FMT_RGBA8;
      endfunction

      function void write_format(csr_idx_type idx, logic [3:0] value);
         if (idx == CSR_SOURCE_FORMAT) begin
            src_fmt = value;
         end else begin
            dst_fmt = value;
         end
      endfunction

      function int pending();
         return exp_pixel.size();
      endfunction

      function logic [7:0] narrow8(logic [15:0] v);
         return 8'(v / 16'd257);
      endfunction

      function chan_type widen(logic [3:0] src, logic [63:0] p);
         chan_type c;
         c = '{r: 16'h0, g: 16'h0, b: 16'h0, a: 16'hFFFF};
         case (src)
            FMT_GS1:   c.r = {16{p[0]}};
            FMT_GS2:   c.r = 16'(p[1:0]) * 16'(STEP_2BIT);
            FMT_GS4:   c.r = 16'(p[3:0]) * 16'(STEP_4BIT);
            FMT_GS8:   c.r = 16'(p[7:0]) * 16'(STEP_8BIT);
            FMT_GS16:  c.r = p[15:0];
            FMT_GSA8: begin
               c.r = 16'(p[15:8]) * 16'(STEP_8BIT);
               c.a = 16'(p[7:0]) * 16'(STEP_8BIT);
            end
            FMT_GSA16: begin
               c.r = p[31:16];
               c.a = p[15:0];
            end
            FMT_RGB8: begin
               c.r = 16'(p[23:16]) * 16'(STEP_8BIT);
               c.g = 16'(p[15:8]) * 16'(STEP_8BIT);
               c.b = 16'(p[7:0]) * 16'(STEP_8BIT);
            end
            FMT_RGB16: begin
               c.r = p[47:32];
               c.g = p[31:16];
               c.b = p[15:0];
            end
            FMT_RGBA8: begin
               c.r = 16'(p[31:24]) * 16'(STEP_8BIT);
               c.g = 16'(p[23:16]) * 16'(STEP_8BIT);
               c.b = 16'(p[15:8]) * 16'(STEP_8BIT);
               c.a = 16'(p[7:0]) * 16'(STEP_8BIT);
            end
            default:   c = p;
         endcase
         if (src <= FMT_GSA16) begin
            c.g = c.r;
            c.b = c.r;
         end
         return c;
      endfunction

      function logic [63:0] pack_target(logic [3:0] dst, chan_type c);
         logic [63:0] total;
         total = 64'(c.r) + 64'(c.g) + 64'(c.b);
         case (dst)
            FMT_GS1:   return total / (64'd3 * STEP_1BIT);
            FMT_GS2:   return total / (64'd3 * STEP_2BIT);
            FMT_GS4:   return total / (64'd3 * STEP_4BIT);
            FMT_GS8:   return total / (64'd3 * STEP_8BIT);
            FMT_GS16:  return total / 64'd3;
            FMT_GSA8:  return ((total / (64'd3 * STEP_8BIT)) << 8) | 64'(narrow8(c.a));
            FMT_GSA16: return ((total / 64'd3) << 16) | 64'(c.a);
            FMT_RGB8:  return {40'd0, narrow8(c.r), narrow8(c.g), narrow8(c.b)};
            default:   return {16'd0, c.r, c.g, c.b};
         endcase
      endfunction

      function void note_request(logic [63:0] pixel);
         chan_type    c;
         logic [63:0] result;
         bit          bad;
         bit          keep_clear;
         result = '0;
         bad = 1'b0;
         c = widen(src_fmt, pixel);
         if (src_fmt > FMT_RGBA16 || dst_fmt > FMT_RGBA16) begin
            bad = 1'b1;
         end else if (dst_fmt == FMT_RGBA16) begin
            if (src_fmt == FMT_RGBA16) bad = 1'b1;
            else result = c;
         end else if (dst_fmt == FMT_RGBA8) begin
            if (src_fmt == FMT_RGBA8) bad = 1'b1;
            else result = {32'd0, narrow8(c.r), narrow8(c.g), narrow8(c.b), narrow8(c.a)};
         end else if (src_fmt == FMT_RGBA8 || src_fmt == FMT_RGBA16) begin
            // transparent pixels go to zero, bar RGBA8 to plain RGB
            keep_clear = (src_fmt == FMT_RGBA8) &&
                         (dst_fmt == FMT_RGB8 || dst_fmt == FMT_RGB16);
            if (!keep_clear && c.a == 16'h0) result = '0;
            else result = pack_target(dst_fmt, c);
         end else begin
            bad = 1'b1;
         end
         exp_pixel.push_back(bad ? 64'h0 : result);
         exp_unsup.push_back(bad);
      endfunction

      function void check_result(logic [63:0] pixel, logic unsup);
         logic [63:0] want_pixel;
         bit          want_unsup;
         if (exp_pixel.size() == 0) begin
            if (mismatches < 10)
               $display("%0t: unexpected transaction: pixel %h unsupported %b",
                        $realtime, pixel, unsup);
            mismatches++;
            return;
         end
         want_pixel = exp_pixel.pop_front();
         want_unsup = exp_unsup.pop_front();
         if (pixel !== want_pixel || unsup !== want_unsup) begin
            if (mismatches < 10)
               $display("%0t: mismatch: expected pixel %h unsupported %b, got pixel %h unsupported %b",
                        $realtime, want_pixel, want_unsup, pixel, unsup);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [63:0] req_pixel_in;
   logic        rsp_strobe;
   logic [63:0] rsp_pixel_out;
   logic        rsp_unsupported;
   logic        csr_we;
   logic        csr_index;
   logic [3:0]  csr_wdata;

   pixel_scoreboard sb = new();
   int          stall_cycles = 0;
   logic [3:0]  cur_src;
   logic [3:0]  cur_dst;

   png_pixel_format_converter DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_pixel_in    (req_pixel_in),
      .rsp_strobe      (rsp_strobe),
      .rsp_pixel_out   (rsp_pixel_out),
      .rsp_unsupported (rsp_unsupported),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         sb.reset_formats();
      end else begin
         if (csr_we) sb.write_format(csr_idx_type'(csr_index), csr_wdata);
         if (start && !busy) sb.note_request(req_pixel_in);
         if (rsp_strobe) sb.check_result(rsp_pixel_out, rsp_unsupported);
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic send_pixel(input logic [63:0] pixel);
      start <= 1'b1;
      req_pixel_in <= pixel;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_burst(input int cycles);
      start <= 1'b0;
      req_pixel_in <= {$urandom, $urandom};
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input csr_idx_type idx, input logic [3:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic set_formats(input logic [3:0] src, input logic [3:0] dst);
      drain();
      write_csr(CSR_SOURCE_FORMAT, src);
      write_csr(CSR_TARGET_FORMAT, dst);
      csr_we <= 1'b0;
      cur_src = src;
      cur_dst = dst;
   endtask

   task automatic directed_pixel(input logic [3:0] src, input logic [3:0] dst,
                                 input logic [63:0] pixel);
      if (src != cur_src || dst != cur_dst) set_formats(src, dst);
      send_pixel(pixel);
   endtask

   function automatic logic [63:0] random_pixel();
      logic [63:0] p;
      p = {$urandom, $urandom};
      case ($urandom_range(0, 15))
         0:       p = '0;
         1:       p = '1;
         2, 3, 4: p[15:0] = 16'h0000;
         5:       p[7:0] = 8'h00;
         6:       p[15:0] = 16'h00FF;
         7:       p[15:0] = 16'h0100;
         default: ;
      endcase
      return p;
   endfunction

   task automatic random_formats();
      logic [3:0] src;
      logic [3:0] dst;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            src = 4'($urandom_range(FMT_GS1, FMT_RGBA16));
            dst = 4'($urandom_range(FMT_RGBA8, FMT_RGBA16));
         end
         4, 5, 6, 7: begin
            src = 4'($urandom_range(FMT_RGBA8, FMT_RGBA16));
            dst = 4'($urandom_range(FMT_GS1, FMT_RGB16));
         end
         8: begin
            src = 4'($urandom_range(0, 15));
            dst = 4'($urandom_range(0, 15));
         end
         default: begin
            src = 4'($urandom_range(FMT_GS1, FMT_RGB16));
            dst = 4'($urandom_range(FMT_GS1, FMT_RGB16));
         end
      endcase
      set_formats(src, dst);
   endtask

   initial begin
      int  sent;
      int  run_len;
      bit  quiet;
      reset <= 1'b1;
      start <= 1'b0;
      req_pixel_in <= '0;
      csr_we <= 1'b0;
      csr_index <= CSR_SOURCE_FORMAT;
      csr_wdata <= '0;
      cur_src = FMT_RGBA16;
      cur_dst = FMT_RGBA8;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      directed_pixel(FMT_RGBA16, FMT_RGBA8, 64'hFFFF_FFFF_FFFF_FFFF);
      directed_pixel(FMT_RGBA16, FMT_RGBA8, 64'h0123_4567_89AB_CDEF);
      directed_pixel(FMT_GS1, FMT_RGBA16, 64'h0000_0000_0000_0001);
      directed_pixel(FMT_GS1, FMT_RGBA16, 64'hFFFF_FFFF_FFFF_FFFE);
      directed_pixel(FMT_GS2, FMT_RGBA8, 64'h0000_0000_0000_0002);
      directed_pixel(FMT_GS2, FMT_RGBA8, 64'h0000_0000_0000_0003);
      directed_pixel(FMT_GSA16, FMT_RGBA16, 64'hAAAA_5555_FFFF_0001);
      directed_pixel(FMT_GSA16, FMT_RGBA8, 64'h0000_0000_8000_8000);
      directed_pixel(FMT_RGBA16, FMT_RGB16, 64'h1111_2222_3333_0001);
      directed_pixel(FMT_RGBA16, FMT_RGB16, 64'h1111_2222_3333_0000);
      directed_pixel(FMT_RGBA8, FMT_RGB8, 64'h0000_0000_AABB_CC00);
      directed_pixel(FMT_RGBA8, FMT_RGB16, 64'h0000_0000_AABB_CC00);
      directed_pixel(FMT_RGBA16, FMT_RGB8, 64'hFFFF_FFFF_FFFF_0000);
      directed_pixel(FMT_RGBA8, FMT_GS1, 64'h0000_0000_FFFF_FFFF);
      directed_pixel(FMT_RGBA8, FMT_GSA8, 64'h0000_0000_1020_3000);
      directed_pixel(FMT_RGBA16, FMT_GS2, 64'h8000_4000_C000_0001);
      directed_pixel(FMT_RGBA16, FMT_GS16, 64'hFFFF_FFFF_FFFF_0000);
      directed_pixel(FMT_RGBA8, FMT_RGBA8, 64'h0000_0000_1234_5678);
      directed_pixel(FMT_RGBA16, FMT_RGBA16, 64'h1234_5678_9ABC_DEF0);
      directed_pixel(FMT_GS8, FMT_RGB8, 64'h0000_0000_0000_00FF);
      directed_pixel(4'd15, FMT_GS1, 64'hFFFF_FFFF_FFFF_FFFF);
      directed_pixel(FMT_GS1, 4'd15, 64'h0000_0000_0000_0001);
      directed_pixel(4'd11, FMT_RGBA16, 64'h0000_0000_0000_0000);

      sent = 0;
      while (sent < RANDOM_PIXELS) begin
         random_formats();
         run_len = $urandom_range(1, 24);
         quiet = (sent >= RANDOM_PIXELS - QUIET_TAIL) || ($urandom_range(0, 3) == 0);
         for (int i = 0; i < run_len && sent < RANDOM_PIXELS; i++) begin
            send_pixel(random_pixel());
            sent++;
            if (!quiet && $urandom_range(0, 3) == 0) idle_burst($urandom_range(1, 13));
         end
      end

      drain();
      repeat (4) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
